// File: sv/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console writer package
// Field widths, command codes, character constants and the internal command
// request type shared by the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int unsigned CMD_W         = 3;
  localparam int unsigned CHAR_W        = 8;
  localparam int unsigned ROW_ARG_W     = 5;
  localparam int unsigned COL_ARG_W     = 7;
  localparam int unsigned ATTR_W        = 8;
  localparam int unsigned CELL_W        = 16;
  localparam int unsigned CURSOR_W      = 11;
  localparam int unsigned S_AXIS_DATA_W = 24;
  localparam int unsigned S_AXIS_USER_W = 3;
  localparam int unsigned M_AXIS_DATA_W = 40;

  localparam logic [CMD_W-1:0] CMD_PUT     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RECOLOR = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SETPOS  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd4;

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

  typedef enum logic [2:0] {
    OP_NOP     = 3'd0,
    OP_PUT     = 3'd1,
    OP_NEWLINE = 3'd2,
    OP_CLEAR   = 3'd3,
    OP_RECOLOR = 3'd4,
    OP_SETPOS  = 3'd5,
    OP_READ    = 3'd6
  } op_e;

  typedef struct packed {
    op_e                  op;
    logic [CHAR_W-1:0]    ch;
    logic [ATTR_W-1:0]    attr;
    logic [ROW_ARG_W-1:0] row;
    logic [COL_ARG_W-1:0] col;
  } cmd_t;

endpackage

// File: sv/tcw_ram.sv
// ----------------------------------------------------------------------------
// Text console writer RAM
// Generic simple dual-port RAM with one write port and one registered read.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/tcw_front.sv
// ----------------------------------------------------------------------------
// Text console writer front end
// Accepts command requests, holds the attribute register and classifies each
// request into an internal operation with saturated or checked arguments.
// ----------------------------------------------------------------------------
module tcw_front #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tcw_pkg::ATTR_W-1:0]          cfg_data_i,
  input  logic                                s_tvalid_i,
  output logic                                s_tready_o,
  input  logic [tcw_pkg::S_AXIS_DATA_W-1:0]   s_tdata_i,
  input  logic [tcw_pkg::S_AXIS_USER_W-1:0]   s_tuser_i,
  input  logic                                queue_full_i,
  input  logic                                init_busy_i,
  output logic                                push_o,
  output tcw_pkg::cmd_t                       cmd_o
);

  import tcw_pkg::*;

  logic [ATTR_W-1:0]    attr_q;
  logic [CMD_W-1:0]     cmd_code;
  logic [CHAR_W-1:0]    char_code;
  logic [ROW_ARG_W-1:0] row_arg;
  logic [COL_ARG_W-1:0] col_arg;
  logic                 row_over;
  logic                 col_over;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else if (cfg_valid_i) begin
      attr_q <= cfg_data_i;
    end
  end

  assign cmd_code  = s_tuser_i[CMD_W-1:0];
  assign char_code = s_tdata_i[CHAR_W-1:0];
  assign row_arg   = s_tdata_i[CHAR_W +: ROW_ARG_W];
  assign col_arg   = s_tdata_i[CHAR_W+ROW_ARG_W +: COL_ARG_W];
  assign row_over  = int'(row_arg) >= int'(ROWS);
  assign col_over  = int'(col_arg) >= int'(COLUMNS);

  assign s_tready_o = !queue_full_i && !init_busy_i;
  assign push_o     = s_tvalid_i && s_tready_o;

  always_comb begin
    cmd_o      = '0;
    cmd_o.op   = OP_NOP;
    cmd_o.ch   = char_code;
    cmd_o.attr = attr_q;
    cmd_o.row  = row_arg;
    cmd_o.col  = col_arg;
    unique case (cmd_code)
      CMD_PUT: begin
        cmd_o.op = (char_code == CH_NEWLINE) ? OP_NEWLINE : OP_PUT;
      end
      CMD_CLEAR: begin
        cmd_o.op = OP_CLEAR;
      end
      CMD_RECOLOR: begin
        cmd_o.op = OP_RECOLOR;
      end
      CMD_SETPOS: begin
        cmd_o.op  = OP_SETPOS;
        cmd_o.row = row_over ? ROW_ARG_W'(ROWS - 1) : row_arg;
        cmd_o.col = col_over ? COL_ARG_W'(COLUMNS - 1) : col_arg;
      end
      CMD_READ: begin
        cmd_o.op = (row_over || col_over) ? OP_NOP : OP_READ;
      end
      default: begin
        cmd_o.op = OP_NOP;
      end
    endcase
  end

endmodule

// File: sv/tcw_queue.sv
// ----------------------------------------------------------------------------
// Text console writer command queue
// Short first-in first-out queue of classified command requests between the
// front end and the back end.
// ----------------------------------------------------------------------------
module tcw_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tcw_pkg::cmd_t data_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          valid_o,
  output tcw_pkg::cmd_t data_o
);

  import tcw_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);

  cmd_t          entries_q [DEPTH];
  logic [PW:0]   wr_ptr_q;
  logic [PW:0]   wr_ptr_d;
  logic [PW:0]   rd_ptr_q;
  logic [PW:0]   rd_ptr_d;

  assign valid_o = wr_ptr_q != rd_ptr_q;
  assign full_o  = (wr_ptr_q[PW] != rd_ptr_q[PW]) && (wr_ptr_q[PW-1:0] == rd_ptr_q[PW-1:0]);
  assign data_o  = entries_q[rd_ptr_q[PW-1:0]];

  assign wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
  assign rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q[PW-1:0]] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

endmodule

// File: sv/tcw_back.sv
// ----------------------------------------------------------------------------
// Text console writer back end
// Sequencer that carries out one command at a time against the screen RAM,
// keeps the write position and hardware cursor, and holds the result register.
// ----------------------------------------------------------------------------
module tcw_back #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cmd_valid_i,
  input  tcw_pkg::cmd_t                     cmd_i,
  output logic                              cmd_pop_o,
  output logic                              init_busy_o,
  output logic                              m_tvalid_o,
  input  logic                              m_tready_i,
  output logic [tcw_pkg::M_AXIS_DATA_W-1:0] m_tdata_o
);

  import tcw_pkg::*;

  localparam int unsigned N  = ROWS * COLUMNS;
  localparam int unsigned AW = $clog2(N);
  localparam int unsigned PW = $clog2(N + 1);
  localparam int unsigned RW = $clog2(ROWS);
  localparam int unsigned CW = $clog2(COLUMNS);

  localparam logic [AW-1:0] COLS_A      = AW'(COLUMNS);
  localparam logic [AW-1:0] LAST_A      = AW'(N - 1);
  localparam logic [AW-1:0] SCR_LAST_A  = AW'(N - COLUMNS - 1);
  localparam logic [AW-1:0] BLANK_FIRST = AW'(N - COLUMNS);
  localparam logic [PW-1:0] COLS_P      = PW'(COLUMNS);
  localparam logic [RW-1:0] ROW_LAST    = RW'(ROWS - 1);
  localparam logic [CW-1:0] COL_LAST    = CW'(COLUMNS - 1);

  typedef enum logic [8:0] {
    S_INIT    = 9'b000000001,
    S_IDLE    = 9'b000000010,
    S_EXEC    = 9'b000000100,
    S_READ    = 9'b000001000,
    S_SCROLL  = 9'b000010000,
    S_RECOLOR = 9'b000100000,
    S_DRAIN   = 9'b001000000,
    S_BLANK   = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_e;

  state_e                   state_q, state_d;
  logic [AW-1:0]            idx_q, idx_d;
  logic [RW-1:0]            row_q, row_d;
  logic [CW-1:0]            col_q, col_d;
  logic [PW-1:0]            hw_q, hw_d;
  logic                     wv_q, wv_d;
  logic [AW-1:0]            wa_q, wa_d;
  logic                     m_valid_q, m_valid_d;
  logic [M_AXIS_DATA_W-1:0] m_data_q, m_data_d;
  cmd_t                     cmd_q, cmd_d;
  logic [AW-1:0]            addr_q, addr_d;
  logic [CELL_W-1:0]        cell_q, cell_d;
  logic                     scrolled_q, scrolled_d;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [CELL_W-1:0]        ram_wdata;
  logic                     ram_re;
  logic [AW-1:0]            ram_raddr;
  logic [CELL_W-1:0]        ram_rdata;
  logic                     row_last;
  logic                     col_last;

  tcw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(N)
  ) u_screen (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign row_last    = row_q == ROW_LAST;
  assign col_last    = col_q == COL_LAST;
  assign init_busy_o = state_q == S_INIT;
  assign m_tvalid_o  = m_valid_q;
  assign m_tdata_o   = m_data_q;

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    row_d      = row_q;
    col_d      = col_q;
    hw_d       = hw_q;
    wv_d       = 1'b0;
    wa_d       = wa_q;
    cmd_d      = cmd_q;
    addr_d     = addr_q;
    cell_d     = cell_q;
    scrolled_d = scrolled_q;
    m_data_d   = m_data_q;
    m_valid_d  = m_valid_q && !m_tready_i;
    cmd_pop_o  = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    ram_we     = wv_q;
    ram_waddr  = wa_q;
    ram_wdata  = (cmd_q.op == OP_RECOLOR) ? {cmd_q.attr, ram_rdata[CHAR_W-1:0]} : ram_rdata;

    unique case (state_q)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = {ATTR_RESET, CH_SPACE};
        if (idx_q == LAST_A) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o  = 1'b1;
          cmd_d      = cmd_i;
          cell_d     = '0;
          scrolled_d = 1'b0;
          if (cmd_i.op == OP_PUT) begin
            addr_d = AW'(row_q) * COLS_A + AW'(col_q);
          end else begin
            addr_d = AW'(cmd_i.row) * COLS_A + AW'(cmd_i.col);
          end
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_DONE;
        unique case (cmd_q.op)
          OP_PUT: begin
            ram_we    = 1'b1;
            ram_waddr = addr_q;
            ram_wdata = {cmd_q.attr, cmd_q.ch};
            hw_d      = PW'(addr_q) + PW'(1);
            if (!col_last) begin
              col_d = col_q + 1'b1;
            end else begin
              col_d = '0;
              if (row_last) begin
                scrolled_d = 1'b1;
                idx_d      = '0;
                state_d    = S_SCROLL;
              end else begin
                row_d = row_q + 1'b1;
              end
            end
          end
          OP_NEWLINE: begin
            col_d = '0;
            if (row_last) begin
              hw_d       = PW'(ROW_LAST) * COLS_P;
              scrolled_d = 1'b1;
              idx_d      = '0;
              state_d    = S_SCROLL;
            end else begin
              row_d = row_q + 1'b1;
              hw_d  = PW'(row_q + 1'b1) * COLS_P;
            end
          end
          OP_CLEAR: begin
            idx_d   = '0;
            state_d = S_BLANK;
          end
          OP_RECOLOR: begin
            idx_d   = '0;
            state_d = S_RECOLOR;
          end
          OP_SETPOS: begin
            row_d = RW'(cmd_q.row);
            col_d = CW'(cmd_q.col);
          end
          OP_READ: begin
            ram_re    = 1'b1;
            ram_raddr = addr_q;
            state_d   = S_READ;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_READ: begin
        cell_d  = ram_rdata;
        state_d = S_DONE;
      end
      S_SCROLL: begin
        ram_re    = 1'b1;
        ram_raddr = idx_q + COLS_A;
        wv_d      = 1'b1;
        wa_d      = idx_q;
        if (idx_q == SCR_LAST_A) begin
          state_d = S_DRAIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_RECOLOR: begin
        ram_re    = 1'b1;
        ram_raddr = idx_q;
        wv_d      = 1'b1;
        wa_d      = idx_q;
        if (idx_q == LAST_A) begin
          state_d = S_DRAIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_DRAIN: begin
        if (cmd_q.op == OP_RECOLOR) begin
          state_d = S_DONE;
        end else begin
          idx_d   = BLANK_FIRST;
          state_d = S_BLANK;
        end
      end
      S_BLANK: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = {cmd_q.attr, CH_SPACE};
        if (idx_q == LAST_A) begin
          state_d = S_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_DONE: begin
        if (!m_valid_q || m_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = {cell_q, scrolled_q, COL_ARG_W'(col_q), ROW_ARG_W'(row_q),
                       CURSOR_W'(hw_q)};
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      idx_q     <= '0;
      row_q     <= '0;
      col_q     <= '0;
      hw_q      <= '0;
      wv_q      <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      row_q     <= row_d;
      col_q     <= col_d;
      hw_q      <= hw_d;
      wv_q      <= wv_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wa_q       <= wa_d;
    cmd_q      <= cmd_d;
    addr_q     <= addr_d;
    cell_q     <= cell_d;
    scrolled_q <= scrolled_d;
    m_data_q   <= m_data_d;
  end

endmodule

// File: sv/text_console_writer_top.sv
// ----------------------------------------------------------------------------
// Text console writer top level
// Text-mode screen buffer engine: put, newline with scrolling, clear, recolor,
// set position and read cell commands, one result per command request.
//
// Channel  Direction  Handshake                    Payload
// cfg      in         cfg_valid_i / cfg_ready_o    cfg_data_i: text attribute
// s_axis   in         s_axis_tvalid / tready       command request
// m_axis   out        m_axis_tvalid / tready       result
//
// A put or newline without scroll, set position, unused command or
// out-of-range read passes states IDLE, EXEC and DONE; an in-range read also
// passes READ. Clear and recolor walk all ROWS*COLUMNS cells through the single
// screen RAM write port, one per cycle; a scroll moves every row but the first
// up by one row and then blanks the last row. After reset a clearing pass fills
// all ROWS*COLUMNS cells (2000 at the defaults) while s_axis is held off. A
// two-entry queue lets requests arrive while the sequencer works, and the
// result register lets the next command run while m_axis stalls.
// ----------------------------------------------------------------------------
module text_console_writer_top #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tcw_pkg::ATTR_W-1:0]          cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // char_code[7:0], row_arg[12:8], col_arg[19:13], zero[23:20]
  input  logic [tcw_pkg::S_AXIS_DATA_W-1:0]   s_axis_tdata,
  // cmd[2:0]
  input  logic [tcw_pkg::S_AXIS_USER_W-1:0]   s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // cursor_index[10:0], write_row[15:11], write_col[22:16], scrolled[23],
  // cell_value[39:24]
  output logic [tcw_pkg::M_AXIS_DATA_W-1:0]   m_axis_tdata
);

  import tcw_pkg::*;

  cmd_t front_cmd;
  cmd_t queue_cmd;
  logic front_push;
  logic queue_full;
  logic queue_valid;
  logic back_pop;
  logic init_busy;

  tcw_front #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_o  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .queue_full_i(queue_full),
    .init_busy_i (init_busy),
    .push_o      (front_push),
    .cmd_o       (front_cmd)
  );

  tcw_queue #(
    .DEPTH(2)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_push),
    .data_i (front_cmd),
    .pop_i  (back_pop),
    .full_o (queue_full),
    .valid_o(queue_valid),
    .data_o (queue_cmd)
  );

  tcw_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(queue_valid),
    .cmd_i      (queue_cmd),
    .cmd_pop_o  (back_pop),
    .init_busy_o(init_busy),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata)
  );

endmodule
